// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define NSC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define NSC_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- hw/rtl/nsc_pkg.sv -----
`timescale 1ns / 1ps

package nsc_pkg;

	// Longest sentence tracked before lengths saturate.
	localparam int MAX_LEN  = 1023;
	localparam int LEN_CAP  = MAX_LEN + 3;
	localparam int CNT_W    = $clog2(LEN_CAP + 1);
	localparam int BODY_W   = 10;
	localparam int BODY_MAX = (MAX_LEN < 1023) ? MAX_LEN : 1023;
	localparam int TALKER_LEN = 6;

	// Queue between front and back.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_EMPTY      = 3'd1;
	localparam logic [2:0] ST_NO_DOLLAR  = 3'd2;
	localparam logic [2:0] ST_NO_SUM     = 3'd3;
	localparam logic [2:0] ST_BAD_SUM    = 3'd4;
	localparam logic [2:0] ST_BAD_TALKER = 3'd5;

	localparam logic [1:0] MODE_IGNORE   = 2'd0;
	localparam logic [1:0] MODE_VALIDATE = 2'd1;
	localparam logic [1:0] MODE_REQUIRE  = 2'd2;

	// Snapshot of one finished sentence, handed from front to back.
	typedef struct packed {
		logic             started;
		logic             dollar;
		logic [7:0]       xor_sum;
		logic [23:0]      tail;
		logic [CNT_W-1:0] count;
		logic             comma_seen;
		logic [CNT_W-1:0] comma_pos;
	} sentence_rec_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

	// Add with saturation at LEN_CAP.
	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
		input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s > (CNT_W+1)'(LEN_CAP))
			return CNT_W'(LEN_CAP);
		return s[CNT_W-1:0];
	endfunction

	// Returns {is_hex, value}.
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		if ((c >= 8'h30) && (c <= 8'h39))
			return {1'b1, c[3:0]};
		if (((c >= 8'h41) && (c <= 8'h46)) || ((c >= 8'h61) && (c <= 8'h66)))
			return {1'b1, c[3:0] + 4'd9};
		return 5'b0;
	endfunction

endpackage

// ----- hw/rtl/nsc_front.sv -----
`timescale 1ns / 1ps

module nsc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            char_byte,
	input  logic                  last_char,
	input  logic                  q_full,
	output logic                  push,
	output nsc_pkg::sentence_rec_t push_rec
);

	logic                     started_q, dollar_q, xor_stop_q, pend_stop_q, comma_seen_q;
	logic [7:0]               xor_q, pend_xor_q;
	logic [23:0]              tail_q;
	logic [15:0]              pend_tail_q;
	logic [nsc_pkg::CNT_W-1:0] pend_n_q, count_q, comma_pos_q;

	logic                     n_started, n_dollar, n_xor_stop, n_pend_stop, n_comma_seen;
	logic [7:0]               n_xor, n_pend_xor;
	logic [23:0]              n_tail;
	logic [15:0]              n_pend_tail;
	logic [nsc_pkg::CNT_W-1:0] n_pend_n, n_count, n_comma_pos;
	logic                     accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && last_char;

	always_comb begin
		n_started    = started_q;
		n_dollar     = dollar_q;
		n_xor        = xor_q;
		n_xor_stop   = xor_stop_q;
		n_tail       = tail_q;
		n_pend_n     = pend_n_q;
		n_pend_xor   = pend_xor_q;
		n_pend_stop  = pend_stop_q;
		n_pend_tail  = pend_tail_q;
		n_count      = count_q;
		n_comma_seen = comma_seen_q;
		n_comma_pos  = comma_pos_q;
		if (!started_q) begin
			if (!nsc_pkg::is_ws(char_byte)) begin
				n_started = 1'b1;
				n_dollar  = (char_byte == nsc_pkg::CH_DOLLAR);
				n_count   = nsc_pkg::CNT_W'(1);
				n_tail    = {16'h0, char_byte};
			end
		end else if (nsc_pkg::is_ws(char_byte)) begin
			// Hold whitespace aside until we know it is interior.
			n_pend_n = nsc_pkg::sat_add(pend_n_q, nsc_pkg::CNT_W'(1));
			if (!pend_stop_q) begin
				if (char_byte == nsc_pkg::CH_CR || char_byte == nsc_pkg::CH_LF)
					n_pend_stop = 1'b1;
				else
					n_pend_xor = pend_xor_q ^ char_byte;
			end
			n_pend_tail = {pend_tail_q[7:0], char_byte};
		end else begin
			// Fold pending whitespace back in, then the byte itself.
			if (pend_n_q != '0) begin
				n_count = nsc_pkg::sat_add(count_q, pend_n_q);
				if (!xor_stop_q) begin
					n_xor = xor_q ^ pend_xor_q;
					if (pend_stop_q)
						n_xor_stop = 1'b1;
				end
				if (pend_n_q >= nsc_pkg::CNT_W'(2))
					n_tail = {tail_q[7:0], pend_tail_q};
				else
					n_tail = {tail_q[15:0], pend_tail_q[7:0]};
			end
			n_pend_n    = '0;
			n_pend_xor  = '0;
			n_pend_stop = 1'b0;
			n_pend_tail = '0;
			if (char_byte == nsc_pkg::CH_COMMA && !comma_seen_q) begin
				n_comma_seen = 1'b1;
				n_comma_pos  = n_count;
			end
			if (!n_xor_stop) begin
				if (char_byte == nsc_pkg::CH_STAR)
					n_xor_stop = 1'b1;
				else
					n_xor = n_xor ^ char_byte;
			end
			n_tail  = {n_tail[15:0], char_byte};
			n_count = nsc_pkg::sat_add(n_count, nsc_pkg::CNT_W'(1));
		end
	end

	assign push_rec = '{started: n_started, dollar: n_dollar, xor_sum: n_xor, tail: n_tail,
		count: n_count, comma_seen: n_comma_seen, comma_pos: n_comma_pos};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q    <= 1'b0;
			dollar_q     <= 1'b0;
			xor_q        <= '0;
			xor_stop_q   <= 1'b0;
			tail_q       <= '0;
			pend_n_q     <= '0;
			pend_xor_q   <= '0;
			pend_stop_q  <= 1'b0;
			pend_tail_q  <= '0;
			count_q      <= '0;
			comma_seen_q <= 1'b0;
			comma_pos_q  <= '0;
		end else if (accept) begin
			if (last_char) begin
				// Sentence done: clear for the next one.
				started_q    <= 1'b0;
				dollar_q     <= 1'b0;
				xor_q        <= '0;
				xor_stop_q   <= 1'b0;
				tail_q       <= '0;
				pend_n_q     <= '0;
				pend_xor_q   <= '0;
				pend_stop_q  <= 1'b0;
				pend_tail_q  <= '0;
				count_q      <= '0;
				comma_seen_q <= 1'b0;
				comma_pos_q  <= '0;
			end else begin
				started_q    <= n_started;
				dollar_q     <= n_dollar;
				xor_q        <= n_xor;
				xor_stop_q   <= n_xor_stop;
				tail_q       <= n_tail;
				pend_n_q     <= n_pend_n;
				pend_xor_q   <= n_pend_xor;
				pend_stop_q  <= n_pend_stop;
				pend_tail_q  <= n_pend_tail;
				count_q      <= n_count;
				comma_seen_q <= n_comma_seen;
				comma_pos_q  <= n_comma_pos;
			end
		end
	end

endmodule

// ----- hw/rtl/nsc_queue.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nsc_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  nsc_pkg::sentence_rec_t push_rec,
	output logic                  full,
	input  logic                  pop,
	output logic                  head_valid,
	output nsc_pkg::sentence_rec_t head_rec
);

	nsc_pkg::sentence_rec_t     entry_q [nsc_pkg::QDEPTH];
	logic [nsc_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [nsc_pkg::QCNT_W-1:0] count_q;
	logic                       do_pop;

	assign full       = (count_q == nsc_pkg::QCNT_W'(nsc_pkg::QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_rec   = entry_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == nsc_pkg::QPTR_W'(nsc_pkg::QDEPTH - 1)) ? '0
					: wr_ptr_q + nsc_pkg::QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == nsc_pkg::QPTR_W'(nsc_pkg::QDEPTH - 1)) ? '0
					: rd_ptr_q + nsc_pkg::QPTR_W'(1);
			if (push && !do_pop)
				count_q <= count_q + nsc_pkg::QCNT_W'(1);
			else if (do_pop && !push)
				count_q <= count_q - nsc_pkg::QCNT_W'(1);
		end
	end

	`NSC_NEVER(a_no_overflow, clk, arst_n, push && full, "queue written while full")
	`NSC_ASSERT(a_count_range, clk, arst_n, count_q <= nsc_pkg::QCNT_W'(nsc_pkg::QDEPTH), "queue count out of range")

endmodule

// ----- hw/rtl/nsc_back.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nsc_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [1:0]                  check_mode,
	input  logic                        head_valid,
	input  nsc_pkg::sentence_rec_t      head_rec,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [2:0]                  status,
	output logic [7:0]                  computed_sum,
	output logic                        sum_present,
	output logic [nsc_pkg::BODY_W-1:0]  body_length
);

	logic                       out_valid_q;
	logic [2:0]                 status_q;
	logic [7:0]                 sum_q;
	logic                       present_q;
	logic [nsc_pkg::BODY_W-1:0] body_q;

	logic                       strip, found, checking;
	logic [4:0]                 hi, lo;
	logic [7:0]                 rcv;
	logic [nsc_pkg::CNT_W-1:0]  body, field;
	logic [2:0]                 c_status;
	logic [7:0]                 c_sum;
	logic                       c_present;
	logic [nsc_pkg::BODY_W-1:0] c_body;

	assign pop = head_valid && (!out_valid_q || out_ready);

	always_comb begin
		strip = (head_rec.count > nsc_pkg::CNT_W'(3))
			&& (head_rec.tail[23:16] == nsc_pkg::CH_STAR);
		hi    = nsc_pkg::hex_nibble(head_rec.tail[15:8]);
		lo    = nsc_pkg::hex_nibble(head_rec.tail[7:0]);
		found = strip && hi[4] && lo[4];
		rcv   = found ? {hi[3:0], lo[3:0]} : 8'h00;
		body  = strip ? head_rec.count - nsc_pkg::CNT_W'(3) : head_rec.count;
		field = (head_rec.comma_seen && (head_rec.comma_pos < body)) ? head_rec.comma_pos : body;
		checking = (check_mode == nsc_pkg::MODE_VALIDATE) || (check_mode == nsc_pkg::MODE_REQUIRE);

		c_sum     = 8'h00;
		c_present = 1'b0;
		c_body    = '0;
		priority if (!head_rec.started) begin
			c_status = nsc_pkg::ST_EMPTY;
		end else if (!head_rec.dollar) begin
			c_status = nsc_pkg::ST_NO_DOLLAR;
		end else begin
			priority if (check_mode == nsc_pkg::MODE_REQUIRE && !found)
				c_status = nsc_pkg::ST_NO_SUM;
			else if (found && checking && (head_rec.xor_sum != rcv))
				c_status = nsc_pkg::ST_BAD_SUM;
			else if (field != nsc_pkg::CNT_W'(nsc_pkg::TALKER_LEN))
				c_status = nsc_pkg::ST_BAD_TALKER;
			else
				c_status = nsc_pkg::ST_OK;
			c_sum     = head_rec.xor_sum;
			c_present = found;
			c_body    = (body > nsc_pkg::CNT_W'(nsc_pkg::BODY_MAX))
				? nsc_pkg::BODY_W'(nsc_pkg::BODY_MAX) : body[nsc_pkg::BODY_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (pop)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q  <= c_status;
			sum_q     <= c_sum;
			present_q <= c_present;
			body_q    <= c_body;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign computed_sum = sum_q;
	assign sum_present  = present_q;
	assign body_length  = body_q;

	`NSC_ASSERT(a_empty_zero, clk, arst_n, (out_valid_q && (status_q == nsc_pkg::ST_EMPTY || status_q == nsc_pkg::ST_NO_DOLLAR)) |-> (sum_q == 8'h00 && !present_q && body_q == '0), "empty or no-dollar result carries data")
	`NSC_ASSERT(a_bad_sum_found, clk, arst_n, (out_valid_q && status_q == nsc_pkg::ST_BAD_SUM) |-> present_q, "bad checksum reported without a checksum")

endmodule

// ----- hw/rtl/nmea_sentence_checker.sv -----
`timescale 1ns / 1ps

// NMEA 0183 sentence checker.
// Input channel (in_valid/in_ready, char_byte, last_char): one sentence character per
// beat; last_char marks the final beat of a sentence. Output channel (out_valid/out_ready,
// status, computed_sum, sum_present, body_length): one result beat per sentence, issued
// for the beat that carried last_char.
// Throughput: one character per cycle while the queue is not full. The front stage
// updates the running sentence state (trim, XOR, tail window, comma position) in the
// cycle a beat is taken. The accepting edge writes a snapshot into a two-entry queue;
// the back then decodes the checksum suffix and loads the output register once it is free.
// Stall: while out_valid is high and out_ready is low the output register holds; the queue
// absorbs up to two finished sentences, and in_ready drops only when the queue is full.
// Configuration: cfg_wr_en writes check_mode (0 ignore, 1 validate if present,
// 2 require, 3 acts as ignore); write only while no sentence is in flight.
// Reset: arst_n clears all sentence state and the queue, drops out_valid and sets
// check_mode to 1.
module nmea_sentence_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [1:0]                 cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 char_byte,
	input  logic                       last_char,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [2:0]                 status,
	output logic [7:0]                 computed_sum,
	output logic                       sum_present,
	output logic [nsc_pkg::BODY_W-1:0] body_length
);

	logic [1:0]             check_mode_q;
	logic                   q_full, push, pop, head_valid;
	nsc_pkg::sentence_rec_t push_rec, head_rec;

	// Mode register: taken straight off the write port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			check_mode_q <= nsc_pkg::MODE_VALIDATE;
		else if (cfg_wr_en)
			check_mode_q <= cfg_wr_data;
	end

	// Front: accept characters, track sentence state, push a snapshot at the last beat.
	nsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_byte (char_byte),
		.last_char (last_char),
		.q_full    (q_full),
		.push      (push),
		.push_rec  (push_rec)
	);

	// Decouple the two sides so a stalled receiver does not stop character intake until the queue is full.
	nsc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_rec   (push_rec),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_rec   (head_rec)
	);

	// Back: decode the suffix, rank the checks, drive the output register.
	nsc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.check_mode   (check_mode_q),
		.head_valid   (head_valid),
		.head_rec     (head_rec),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.computed_sum (computed_sum),
		.sum_present  (sum_present),
		.body_length  (body_length)
	);

endmodule
